FILE: sv/auip_pkg.sv
// Shared types, codes and character helpers for the ASCII unsigned integer parser.
package auip_pkg;

    typedef enum logic [1:0] {
        PH_SKIP   = 2'd0,
        PH_DIGITS = 2'd1
    } phase_t;

    typedef enum logic [1:0] {
        ST_SUCCESS  = 2'd0,
        ST_NO_DIGIT = 2'd1,
        ST_OVERFLOW = 2'd2
    } status_t;

    localparam int unsigned CHAR_W   = 8;
    localparam int unsigned BASE_W   = 6;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned VALUE_W  = 16;
    localparam int unsigned OFFSET_W = 8;
    localparam int unsigned RESULT_W = STATUS_W + VALUE_W + OFFSET_W;
    localparam int unsigned RESULT_BYTES_W = ((RESULT_W + 7) / 8) * 8;

    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;

    localparam logic [BASE_W-1:0] DIGIT_NONE = 6'd36;
    localparam logic [BASE_W-1:0] BASE_MIN   = 6'd2;
    localparam logic [BASE_W-1:0] BASE_MAX   = 6'd36;
    localparam logic [BASE_W-1:0] BASE_RESET = 6'd10;

    localparam int unsigned     APB_ADDR_W        = 2;
    localparam logic [1:0]      REG_NUMBER_BASE   = 2'd0;

    // Map an ASCII byte to its digit value, or DIGIT_NONE for anything else.
    function automatic logic [BASE_W-1:0] digit_of(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] d;
        begin
            d = CHAR_W'(DIGIT_NONE);
            if (c >= 8'h30 && c <= 8'h39)
            begin
                d = c - 8'h30;
            end
            else if (c >= 8'h41 && c <= 8'h5A)
            begin
                d = c - 8'h37;
            end
            else if (c >= 8'h61 && c <= 8'h7A)
            begin
                d = c - 8'h57;
            end
            return d[BASE_W-1:0];
        end
    endfunction

endpackage

FILE: sv/ascii_unsigned_integer_parser.sv
// Top level of the streaming ASCII unsigned integer parser.
//
// Usage:
//   Characters enter one per item on the s_axis channel (tdata = one ASCII
//   byte). Leading spaces and tabs are skipped, one '+' may follow, then
//   digits in the radix held in the number_base register (APB, address 0,
//   reset value 10). The first character that is not a valid digit ends the
//   string: it is not counted, and it alone produces one result item on
//   m_axis carrying status, value and end_offset. The parser then re-arms.
//   A radix outside 2..36 makes every character end a string at once.
//
// Timing:
//   An accepted item is held in the input register; its result, if any, is
//   then registered in the result register and shown on m_axis. The
//   accumulator update is a single multiply-add by the 6-bit radix, so one
//   character is taken every cycle, back to back, unless a terminator stalls.
//
// Reset and stalls:
//   rst_n clears the parse state, the radix to 10 and both valid flags.
//   While a result waits on m_axis, characters that produce no result keep
//   flowing; only a terminating character stalls in the input register, and
//   s_axis_tready drops once that register is full and cannot advance.
module ascii_unsigned_integer_parser #(
    parameter int unsigned VALUE_BITS    = 16,
    parameter int unsigned POSITION_BITS = 8
) (
    input  logic        clk,
    input  logic        rst_n,

    // APB configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [auip_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,

    // Character input
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] character

    // Result output
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [auip_pkg::RESULT_BYTES_W-1:0] m_axis_tdata
    // m_axis_tdata: [1:0] status, [17:2] value, [25:18] end_offset, rest zero
);

    localparam int unsigned PROD_W  = VALUE_BITS + auip_pkg::BASE_W;
    localparam int unsigned VEXT_W  = (VALUE_BITS > auip_pkg::VALUE_W) ?
                                      VALUE_BITS : auip_pkg::VALUE_W;
    localparam int unsigned PEXT_W  = (POSITION_BITS > auip_pkg::OFFSET_W) ?
                                      POSITION_BITS : auip_pkg::OFFSET_W;
    localparam logic [PEXT_W-1:0] OFFSET_SAT = PEXT_W'({auip_pkg::OFFSET_W{1'b1}});

    // Configuration
    logic [auip_pkg::BASE_W-1:0] base_reg;
    logic                        cfg_write;

    // Input register
    logic                        s1_valid_reg;
    logic [auip_pkg::CHAR_W-1:0] s1_char_reg;

    // Parse state
    auip_pkg::phase_t            phase_reg, phase_next;
    logic [VALUE_BITS-1:0]       acc_reg;
    logic                        seen_reg;
    logic                        ovf_reg;
    logic [POSITION_BITS-1:0]    pos_reg;

    // Result register
    logic                        m_valid_reg;
    auip_pkg::status_t           m_status_reg;
    logic [auip_pkg::VALUE_W-1:0]  m_value_reg;
    logic [auip_pkg::OFFSET_W-1:0] m_offset_reg;

    // Datapath
    logic                        base_ok;
    logic                        is_ws;
    logic                        is_plus;
    logic [auip_pkg::BASE_W-1:0] digit;
    logic [PROD_W-1:0]           prod;
    logic                        prod_ovf;
    logic                        emit;
    logic                        rearm;
    logic                        count;
    logic                        take_digit;
    auip_pkg::status_t           r_status;
    logic [auip_pkg::VALUE_W-1:0]  r_value;
    logic [auip_pkg::OFFSET_W-1:0] r_offset;
    logic [VEXT_W-1:0]           acc_ext;
    logic [PEXT_W-1:0]           pos_ext;
    logic                        out_free;
    logic                        s1_fire;

    // ---------------- configuration port ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready &&
                       (paddr == auip_pkg::REG_NUMBER_BASE);
    assign prdata    = (paddr == auip_pkg::REG_NUMBER_BASE) ? 32'(base_reg) : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= auip_pkg::BASE_RESET;
        end
        else if (cfg_write)
        begin
            base_reg <= pwdata[auip_pkg::BASE_W-1:0];
        end
    end

    // ---------------- character decode ----------------
    assign base_ok  = (base_reg >= auip_pkg::BASE_MIN) && (base_reg <= auip_pkg::BASE_MAX);
    assign is_ws    = (s1_char_reg == auip_pkg::CHAR_SPACE) ||
                      (s1_char_reg == auip_pkg::CHAR_TAB);
    assign is_plus  = (s1_char_reg == auip_pkg::CHAR_PLUS);
    assign digit    = auip_pkg::digit_of(s1_char_reg);

    // Exact overflow: any bit above the value width means the result does not fit.
    assign prod     = PROD_W'(acc_reg) * PROD_W'(base_reg) + PROD_W'(digit);
    assign prod_ovf = |prod[PROD_W-1:VALUE_BITS];

    assign acc_ext  = VEXT_W'(acc_reg);
    assign pos_ext  = PEXT_W'(pos_reg);

    // Next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (s1_fire)
        begin
            priority if (rearm)
            begin
                phase_next = auip_pkg::PH_SKIP;
            end
            else if (phase_reg == auip_pkg::PH_SKIP && is_ws)
            begin
                phase_next = auip_pkg::PH_SKIP;
            end
            else
            begin
                phase_next = auip_pkg::PH_DIGITS;
            end
        end
    end

    // Per-character actions and result fields
    always_comb
    begin
        emit       = 1'b0;
        rearm      = 1'b0;
        count      = 1'b0;
        take_digit = 1'b0;
        r_status   = auip_pkg::ST_SUCCESS;
        priority if (!base_ok)
        begin
            emit     = 1'b1;
            rearm    = 1'b1;
            r_status = auip_pkg::ST_NO_DIGIT;
        end
        else if (phase_reg == auip_pkg::PH_SKIP && (is_ws || is_plus))
        begin
            count = 1'b1;
        end
        else if (digit >= base_reg)
        begin
            // Terminator: close the string.
            emit  = 1'b1;
            rearm = 1'b1;
            priority if (!seen_reg)
            begin
                r_status = auip_pkg::ST_NO_DIGIT;
            end
            else if (ovf_reg)
            begin
                r_status = auip_pkg::ST_OVERFLOW;
            end
            else
            begin
                r_status = auip_pkg::ST_SUCCESS;
            end
        end
        else
        begin
            count      = 1'b1;
            take_digit = 1'b1;
        end

        if (r_status == auip_pkg::ST_SUCCESS)
        begin
            r_value  = acc_ext[auip_pkg::VALUE_W-1:0];
            r_offset = (pos_ext > OFFSET_SAT) ? {auip_pkg::OFFSET_W{1'b1}}
                                              : pos_ext[auip_pkg::OFFSET_W-1:0];
        end
        else
        begin
            r_value  = '0;
            r_offset = '0;
        end
    end

    // ---------------- flow control ----------------
    // Only a terminator needs the result register; others always advance.
    assign out_free      = !m_valid_reg || m_axis_tready;
    assign s1_fire       = s1_valid_reg && (!emit || out_free);
    assign s_axis_tready = !s1_valid_reg || s1_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            s1_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            s1_char_reg <= s_axis_tdata;
        end
    end

    // ---------------- parse state ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= auip_pkg::PH_SKIP;
            acc_reg   <= '0;
            seen_reg  <= 1'b0;
            ovf_reg   <= 1'b0;
            pos_reg   <= '0;
        end
        else if (s1_fire)
        begin
            phase_reg <= phase_next;
            if (rearm)
            begin
                acc_reg  <= '0;
                seen_reg <= 1'b0;
                ovf_reg  <= 1'b0;
                pos_reg  <= '0;
            end
            else
            begin
                // Saturate the position count at all ones.
                if (count && (pos_reg != {POSITION_BITS{1'b1}}))
                begin
                    pos_reg <= pos_reg + 1'b1;
                end
                if (take_digit)
                begin
                    seen_reg <= 1'b1;
                    if (!ovf_reg)
                    begin
                        if (prod_ovf)
                        begin
                            ovf_reg <= 1'b1;
                        end
                        else
                        begin
                            acc_reg <= prod[VALUE_BITS-1:0];
                        end
                    end
                end
            end
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            m_valid_reg <= s1_fire && emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && emit)
        begin
            m_status_reg <= r_status;
            m_value_reg  <= r_value;
            m_offset_reg <= r_offset;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = auip_pkg::RESULT_BYTES_W'({m_offset_reg, m_value_reg, m_status_reg});

endmodule

FILE: sv/auip_checker.sv
// Port-level checker for the ASCII unsigned integer parser, with its bind.
module auip_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [auip_pkg::RESULT_BYTES_W-1:0] m_axis_tdata
);

    // Hold a stalled result unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result changed or dropped");

    // Status is always one of the three defined codes.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[1:0] == auip_pkg::ST_SUCCESS ||
                           m_axis_tdata[1:0] == auip_pkg::ST_NO_DIGIT ||
                           m_axis_tdata[1:0] == auip_pkg::ST_OVERFLOW))
        else $error("undefined status code");

    // Failed parses carry zero value and zero offset.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[1:0] != auip_pkg::ST_SUCCESS)
            |-> (m_axis_tdata[25:2] == '0))
        else $error("failed parse with nonzero value or offset");

    // Padding bits stay zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[auip_pkg::RESULT_BYTES_W-1:auip_pkg::RESULT_W] == '0))
        else $error("padding bits set");

endmodule

bind ascii_unsigned_integer_parser auip_checker u_auip_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
